// ===== hdl/arp_cache_responder_defines.svh =====
`ifndef ARP_CACHE_RESPONDER_DEFINES_SVH
`define ARP_CACHE_RESPONDER_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define ARPCR_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// implication into the following cycle
`define ARPCR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/arpcr_pkg.sv =====
package arpcr_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  // register select (address bit 3)
  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP  = 1'b1;

  // queue between classifier and sequencer
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_NONE,    // all-zero result
    OP_REPLY,   // reply without learning (sender ip zero)
    OP_LOOKUP,  // scan for first match
    OP_LEARN    // scan, update or insert, reply
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } q_item_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic             send_reply;
    logic [MAC_W-1:0] reply_mac;
    logic [IP_W-1:0]  reply_ip;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

endpackage

// ===== hdl/arpcr_front.sv =====
`include "arp_cache_responder_defines.svh"

module arpcr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic                          s_command,
  input  logic [arpcr_pkg::IP_W-1:0]    s_query_ip,
  input  logic [arpcr_pkg::MAC_W-1:0]   s_sender_mac,
  input  logic [arpcr_pkg::IP_W-1:0]    s_sender_ip,
  input  logic [arpcr_pkg::IP_W-1:0]    own_ip,
  output logic                          q_valid,
  output arpcr_pkg::q_item_t            q_item,
  input  logic                          q_pop
);
  import arpcr_pkg::*;

  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  q_item_t           fifo_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  q_item_t           cls;
  logic              push;

  // classify the incoming word
  always_comb begin
    cls.op  = OP_NONE;
    cls.ip  = '0;
    cls.mac = '0;
    priority if (s_command == CMD_LOOKUP) begin
      cls.op = (s_query_ip == '0) ? OP_NONE : OP_LOOKUP;
      cls.ip = s_query_ip;
    end else if (s_command == CMD_PACKET && s_query_ip == own_ip) begin
      cls.op  = (s_sender_ip == '0) ? OP_REPLY : OP_LEARN;
      cls.ip  = s_sender_ip;
      cls.mac = s_sender_mac;
    end else begin
      cls.op = OP_NONE;
    end
  end

  assign s_ready = (count != CNT_FULL);
  assign push    = s_valid && s_ready;
  assign q_valid = (count != '0);
  assign q_item  = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= cls;
    end
  end

  `ARPCR_ASSERT(a_pop_nonempty, q_pop, count != '0, "pop from empty queue")
  `ARPCR_ASSERT_NEXT(a_fill, push && !q_pop, count == $past(count) + 1'b1, "queue count did not rise")
  `ARPCR_ASSERT_NEXT(a_drain, q_pop && !push, count == $past(count) - 1'b1, "queue count did not fall")

endmodule

// ===== hdl/arpcr_back.sv =====
`include "arp_cache_responder_defines.svh"

module arpcr_back #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  arpcr_pkg::q_item_t  q_item,
  output logic                q_pop,
  output logic                m_valid,
  input  logic                m_ready,
  output arpcr_pkg::result_t  m_result
);
  import arpcr_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

  logic [IP_W-1:0]  ip_mem  [CACHE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] vld;

  bk_state_t        state;
  bk_state_t        state_next;
  q_item_t          cur;
  logic [CNT_W-1:0] rd_cnt;
  logic             cmp_act;
  logic [IDX_W-1:0] cmp_idx;
  logic [IP_W-1:0]  rd_ip;
  logic [MAC_W-1:0] rd_mac;
  logic             rd_vld;
  logic             found;
  logic [MAC_W-1:0] found_mac;
  logic             seen;
  logic             have_free;
  logic [IDX_W-1:0] slot;
  logic             out_valid;
  result_t          out_res;

  logic             out_free;
  logic             is_direct;
  logic             cmp_match;
  logic             rd_issue;
  logic             ip_we;
  logic             mac_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IP_W-1:0]  wr_ip;
  logic [MAC_W-1:0] wr_mac;
  logic             out_load;
  result_t          out_next;

  assign out_free  = !out_valid || m_ready;
  assign is_direct = (q_item.op == OP_NONE) || (q_item.op == OP_REPLY);
  assign cmp_match = cmp_act && rd_vld && (rd_ip == cur.ip);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && out_free && !is_direct) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (cmp_act && cmp_idx == IDX_LAST) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    rd_issue = 1'b0;
    ip_we    = 1'b0;
    mac_we   = 1'b0;
    wr_addr  = cmp_idx;
    wr_ip    = cur.ip;
    wr_mac   = cur.mac;
    out_load = 1'b0;
    out_next = '0;
    unique case (state)
      BK_IDLE: begin
        q_pop = q_valid && out_free;
        if (q_pop && is_direct) begin
          out_load = 1'b1;
          if (q_item.op == OP_REPLY) begin
            out_next.send_reply = 1'b1;
            out_next.reply_mac  = q_item.mac;
            out_next.reply_ip   = q_item.ip;
          end
        end
      end
      BK_SCAN: begin
        rd_issue = (rd_cnt != CNT_END);
        // rewrite every matching entry
        if (cur.op == OP_LEARN && cmp_match) begin
          mac_we = 1'b1;
        end
      end
      BK_DONE: begin
        out_load = 1'b1;
        if (cur.op == OP_LOOKUP) begin
          out_next.hit       = found;
          out_next.found_mac = found_mac;
        end else begin
          out_next.send_reply = 1'b1;
          out_next.reply_mac  = cur.mac;
          out_next.reply_ip   = cur.ip;
          // no match: first empty entry, or entry 0 when full
          if (!seen) begin
            ip_we   = 1'b1;
            mac_we  = 1'b1;
            wr_addr = slot;
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      cmp_act   <= 1'b0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_act <= rd_issue;
      if (ip_we) begin
        vld[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= q_item;
      rd_cnt    <= '0;
      found     <= 1'b0;
      found_mac <= '0;
      seen      <= 1'b0;
      have_free <= 1'b0;
      slot      <= '0;
    end
    if (rd_issue) begin
      rd_cnt  <= rd_cnt + 1'b1;
      cmp_idx <= rd_cnt[IDX_W-1:0];
      rd_ip   <= ip_mem[rd_cnt[IDX_W-1:0]];
      rd_mac  <= mac_mem[rd_cnt[IDX_W-1:0]];
      rd_vld  <= vld[rd_cnt[IDX_W-1:0]];
    end
    if (cmp_match && !found) begin
      found     <= 1'b1;
      found_mac <= rd_mac;
    end
    if (cmp_match) begin
      seen <= 1'b1;
    end
    if (cmp_act && !rd_vld && !have_free) begin
      have_free <= 1'b1;
      slot      <= cmp_idx;
    end
    if (out_load) begin
      out_res <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ip_we) begin
      ip_mem[wr_addr] <= wr_ip;
    end
    if (mac_we) begin
      mac_mem[wr_addr] <= wr_mac;
    end
  end

  assign m_valid  = out_valid;
  assign m_result = out_res;

  `ARPCR_ASSERT(a_load_free, out_load, !out_valid || m_ready, "result overwritten before taken")
  `ARPCR_ASSERT(a_cmp_scan, cmp_act, state == BK_SCAN, "compare active outside scan")
  `ARPCR_ASSERT(a_one_kind, out_valid, !(out_res.hit && out_res.send_reply), "hit and reply together")

endmodule

// ===== hdl/arp_cache_responder.sv =====
// arp cache and responder: keeps CACHE_ENTRIES ipv4-to-mac pairs, all empty after reset
// (per-entry valid flags clear at once, no clearing pass). a word on the slave stream is a
// lookup (tuser 0) or a received arp packet (tuser 1); every word gives exactly one result
// word in order. lookups of a nonzero ip and packets that target own_ip with a nonzero
// sender ip walk the whole table through one memory read port, one entry per cycle; all
// other words go straight from the queue to the result register. a two-word queue after
// the classifier lets the slave side take up to two words while the table walk runs, and
// the result register holds the finished word until the master side takes it.
// learning rewrites every entry with the sender ip, else fills the lowest empty entry, or
// entry 0 when full; an ip of zero is never stored and never hits. own_mac sits at byte
// address 0 and own_ip at 8 (address bit 3 selects); write them only while idle.
module arp_cache_responder #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // query_ip[31:0], sender_mac[79:32], sender_ip[111:80]
  input  logic [0:0]   s_tuser,   // command[0]
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // found_mac[47:0], reply_mac[95:48], reply_ip[127:96]
  output logic [1:0]   m_tuser    // hit[0], send_reply[1]
);
  import arpcr_pkg::*;

  logic [MAC_W-1:0] own_mac;
  logic [IP_W-1:0]  own_ip;
  logic             cfg_wr;

  logic             q_valid;
  logic             q_pop;
  q_item_t          q_item;
  result_t          res;

  // register file, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_OWN_MAC: own_mac <= pwdata[MAC_W-1:0];
        REG_OWN_IP:  own_ip  <= pwdata[IP_W-1:0];
        default:     own_ip  <= own_ip;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_OWN_MAC: prdata = {16'b0, own_mac};
      REG_OWN_IP:  prdata = {32'b0, own_ip};
      default:     prdata = '0;
    endcase
  end

  // classifier and queue
  arpcr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .s_command    (s_tuser[0]),
    .s_query_ip   (s_tdata[31:0]),
    .s_sender_mac (s_tdata[79:32]),
    .s_sender_ip  (s_tdata[111:80]),
    .own_ip       (own_ip),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // table walk, update and result register
  arpcr_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_result (res)
  );

  // result word packing
  assign m_tdata = {res.reply_ip, res.reply_mac, res.found_mac};
  assign m_tuser = {res.send_reply, res.hit};

endmodule
